// ===== hdl/rv32id_pkg.sv =====
package rv32id_pkg;

	// major opcodes
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

	// funct7 codes
	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;
	localparam logic [6:0] F7_MEXT = 7'b0000001;

	// funct3 codes that steer decoding
	localparam logic [2:0] F3_ADD   = 3'd0;
	localparam logic [2:0] F3_SLL   = 3'd1;
	localparam logic [2:0] F3_SR    = 3'd5;
	localparam logic [2:0] F3_JALR  = 3'd0;
	localparam logic [2:0] F3_SW    = 3'd2;

	// exact system words
	localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
	localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

	typedef logic [5:0] mnem_t;

	// dense mnemonic numbering, unknown is zero
	localparam mnem_t MN_UNKNOWN = 6'd0;
	localparam mnem_t MN_ADD     = 6'd1;
	localparam mnem_t MN_SUB     = 6'd2;
	localparam mnem_t MN_SRA     = 6'd8;
	localparam mnem_t MN_MUL     = 6'd11;
	localparam mnem_t MN_SLLI    = 6'd25;
	localparam mnem_t MN_SRLI    = 6'd26;
	localparam mnem_t MN_SRAI    = 6'd27;
	localparam mnem_t MN_SB      = 6'd39;
	localparam mnem_t MN_LUI     = 6'd42;
	localparam mnem_t MN_AUIPC   = 6'd43;
	localparam mnem_t MN_JAL     = 6'd44;
	localparam mnem_t MN_JALR    = 6'd45;
	localparam mnem_t MN_ECALL   = 6'd46;
	localparam mnem_t MN_EBREAK  = 6'd47;

	// per-funct3 lookup, zero marks an unlisted combination
	localparam mnem_t RR_BASE [8] = '{6'd1, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd9, 6'd10};
	localparam mnem_t OI_MAP  [8] = '{6'd19, 6'd25, 6'd20, 6'd21, 6'd22, 6'd26, 6'd23,
		6'd24};
	localparam mnem_t LD_MAP  [8] = '{6'd28, 6'd29, 6'd30, 6'd0, 6'd31, 6'd32, 6'd0, 6'd0};
	localparam mnem_t BR_MAP  [8] = '{6'd33, 6'd34, 6'd0, 6'd0, 6'd35, 6'd36, 6'd37, 6'd38};

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] pc_address;
	} in_item_t;

	typedef struct packed {
		logic               known;
		mnem_t              mnemonic;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] imm_value;
		logic               has_target;
		logic [31:0]        target_address;
	} out_item_t;

	// immediates by format
	function automatic logic [31:0] imm_i(input logic [31:0] w);
		return {{20{w[31]}}, w[31:20]};
	endfunction

	function automatic logic [31:0] imm_s(input logic [31:0] w);
		return {{20{w[31]}}, w[31:25], w[11:7]};
	endfunction

	function automatic logic [31:0] imm_b(input logic [31:0] w);
		return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	endfunction

	function automatic logic [31:0] imm_j(input logic [31:0] w);
		return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
	endfunction

	function automatic logic [31:0] imm_u(input logic [31:0] w);
		return {w[31:12], 12'h000};
	endfunction

endpackage

// ===== hdl/rv32id_stream_if.sv =====
interface rv32id_stream_if #(parameter type payload_t = logic [0:0]);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/rv32id_decode.sv =====
module rv32id_decode (
	input  rv32id_pkg::in_item_t  item,
	output rv32id_pkg::out_item_t result
);
	import rv32id_pkg::*;

	logic [31:0] w;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	mnem_t       mn;
	logic [31:0] imm;
	logic        has_t;

	assign w   = item.instr_word;
	assign opc = w[6:0];
	assign f3  = w[14:12];
	assign f7  = w[31:25];

	// mnemonic and immediate by opcode
	always_comb begin
		mn    = MN_UNKNOWN;
		imm   = '0;
		has_t = 1'b0;
		unique case (opc)
			OPC_OP: begin
				priority if (f7 == F7_BASE) begin
					mn = RR_BASE[f3];
				end else if (f7 == F7_MEXT) begin
					mn = MN_MUL + {3'b000, f3};
				end else if (f7 == F7_ALT && f3 == F3_ADD) begin
					mn = MN_SUB;
				end else if (f7 == F7_ALT && f3 == F3_SR) begin
					mn = MN_SRA;
				end else begin
					mn = MN_UNKNOWN;
				end
			end
			OPC_OPIMM: begin
				priority if (f3 == F3_SLL) begin
					mn = (f7 == F7_BASE) ? MN_SLLI : MN_UNKNOWN;
				end else if (f3 == F3_SR) begin
					mn = (f7 == F7_BASE) ? MN_SRLI :
						((f7 == F7_ALT) ? MN_SRAI : MN_UNKNOWN);
				end else begin
					mn = OI_MAP[f3];
				end
				if (mn != MN_UNKNOWN) begin
					imm = imm_i(w);
				end
			end
			OPC_LOAD: begin
				mn = LD_MAP[f3];
				if (mn != MN_UNKNOWN) begin
					imm = imm_i(w);
				end
			end
			OPC_BRANCH: begin
				mn = BR_MAP[f3];
				if (mn != MN_UNKNOWN) begin
					imm   = imm_b(w);
					has_t = 1'b1;
				end
			end
			OPC_STORE: begin
				if (f3 <= F3_SW) begin
					mn  = MN_SB + {3'b000, f3};
					imm = imm_s(w);
				end
			end
			OPC_LUI: begin
				mn  = MN_LUI;
				imm = imm_u(w);
			end
			OPC_AUIPC: begin
				mn  = MN_AUIPC;
				imm = imm_u(w);
			end
			OPC_JAL: begin
				mn    = MN_JAL;
				imm   = imm_j(w);
				has_t = 1'b1;
			end
			OPC_JALR: begin
				if (f3 == F3_JALR) begin
					mn  = MN_JALR;
					imm = imm_i(w);
				end
			end
			OPC_SYSTEM: begin
				priority if (w == WORD_ECALL) begin
					mn = MN_ECALL;
				end else if (w == WORD_EBREAK) begin
					mn  = MN_EBREAK;
					imm = 32'd1;
				end else begin
					mn = MN_UNKNOWN;
				end
			end
			default: begin
				mn = MN_UNKNOWN;
			end
		endcase
	end

	// pack the result, target only for branch and jal
	always_comb begin
		result.known          = (mn != MN_UNKNOWN);
		result.mnemonic       = mn;
		result.dest_reg       = w[11:7];
		result.src1_reg       = w[19:15];
		result.src2_reg       = w[24:20];
		result.imm_value      = imm;
		result.has_target     = has_t;
		result.target_address = has_t ? (item.pc_address + imm) : '0;
	end

endmodule

// ===== hdl/rv32im_instruction_decoder_unit.sv =====
// RV32IM instruction decoder. Each item is one instruction word and its address; the result
// item gives a known flag, the dense mnemonic number, the raw rd/rs1/rs2 fields, the
// sign-extended immediate of the format and, for branches and JAL, pc plus offset. One item
// is taken every clock cycle while the output side does not stall. An accepted item passes
// through the input register and then the result register, with the decode and target adder
// between them, before its result is presented.
// Ready on the input follows the result side through the two stages, so a stall on the output
// holds the pipe and nothing is dropped.
module rv32im_instruction_decoder_unit (
	input logic             clk,
	input logic             arst_n,
	rv32id_stream_if.sink   instr,
	rv32id_stream_if.source dec
);
	import rv32id_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	out_item_t result_d;
	logic      adv_s1;
	logic      adv_s2;

	// stage advance
	assign adv_s2      = !valid_s2 || dec.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign instr.ready = adv_s1;

	rv32id_decode u_decode (
		.item   (item_s1),
		.result (result_d)
	);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= instr.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv_s1 && instr.valid) begin
			item_s1 <= instr.data;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign dec.valid = valid_s2;
	assign dec.data  = result_s2;

`ifndef SYNTH
	a_known_matches_mnemonic: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid |-> dec.data.known == (dec.data.mnemonic != MN_UNKNOWN))
		else $error("known flag disagrees with mnemonic");

	a_target_needs_known: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && dec.data.has_target |-> dec.data.known)
		else $error("target on an unknown instruction");

	a_no_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && !dec.data.has_target |-> dec.data.target_address == 32'd0)
		else $error("target address set without a target");

	a_unknown_imm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && !dec.data.known |-> dec.data.imm_value == 32'sd0)
		else $error("immediate set on an unknown instruction");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		instr.valid && instr.ready |=> valid_s1)
		else $error("accepted item missing from first stage");
`endif

endmodule
